// ===== rtl/char_lcd_nibble_sequencer_core_defines.svh =====
// Assertion macros shared by the character LCD nibble sequencer RTL.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_CORE_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define LCDNS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcdns assertion failed");
`define LCDNS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcdns assertion failed");
`else
`define LCDNS_ASSERT_IMPLY(lbl, ante, cons)
`define LCDNS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/lcdns_pkg.sv =====
// Package with codes, types and tables for the character LCD nibble sequencer.
package lcdns_pkg;

  localparam logic [2:0] CMD_INSTR  = 3'd0;
  localparam logic [2:0] CMD_DATA   = 3'd1;
  localparam logic [2:0] CMD_CURSOR = 3'd2;
  localparam logic [2:0] CMD_INIT   = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;
  localparam logic [2:0] CMD_STROBE = 3'd5;
  localparam logic [2:0] CMD_GLYPH  = 3'd6;
  localparam logic [2:0] CMD_NONE   = 3'd7;

  localparam logic [2:0] K_HI   = 3'd0;
  localparam logic [2:0] K_LO   = 3'd1;
  localparam logic [2:0] K_ON   = 3'd2;
  localparam logic [2:0] K_OFF  = 3'd3;
  localparam logic [2:0] K_IDLE = 3'd4;
  localparam logic [2:0] K_X38  = 3'd5;
  localparam logic [2:0] K_X28  = 3'd6;

  localparam logic [1:0] SEL_REQ   = 2'd0;
  localparam logic [1:0] SEL_INIT  = 2'd1;
  localparam logic [1:0] SEL_CLEAR = 2'd2;

  localparam logic [7:0] PORT_BL     = 8'h08;
  localparam logic [7:0] PORT_EN     = 8'h04;
  localparam logic [7:0] PORT_NEN    = 8'hFB;
  localparam logic [7:0] PORT_RS     = 8'h01;
  localparam logic [7:0] NIB_HI      = 8'hF0;
  localparam logic [7:0] PORT_RESET  = 8'hFF;
  localparam logic [7:0] INIT_8BIT   = 8'h30;
  localparam logic [7:0] INIT_4BIT   = 8'h20;
  localparam logic [7:0] CURSOR_BASE = 8'h80;
  localparam logic [7:0] CGRAM_BASE  = 8'h40;

  localparam logic [2:0] SEND_LAST_STEP  = 3'd6;
  localparam logic [2:0] PRE_LAST_STEP   = 3'd7;
  localparam logic [2:0] PRE_STROBE_STEP = 3'd6;
  localparam logic [2:0] INIT_LAST_IDX   = 3'd5;
  localparam logic [2:0] CLEAR_LAST_IDX  = 3'd1;

  typedef struct packed {
    logic       issue;
    logic       load;
    logic [2:0] kind;
    logic [1:0] sel;
    logic [2:0] idx;
    logic       tail;
  } lcdns_cmd_t;

  function automatic logic [2:0] send_kind(input logic [2:0] step);
    logic [2:0] k;
    case (step)
      3'd0: k = K_HI;
      3'd1: k = K_ON;
      3'd2: k = K_OFF;
      3'd3: k = K_LO;
      3'd4: k = K_ON;
      3'd5: k = K_OFF;
      default: k = K_IDLE;
    endcase
    return k;
  endfunction

  function automatic logic [2:0] prefix_kind(input logic [2:0] step);
    logic [2:0] k;
    case (step)
      3'd0: k = K_X38;
      3'd3: k = K_X28;
      3'd1, 3'd4, 3'd6: k = K_ON;
      default: k = K_OFF;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h28;
      3'd1: b = 8'h08;
      3'd2: b = 8'h01;
      3'd3: b = 8'h06;
      3'd4: b = 8'h0C;
      default: b = 8'h0F;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] clear_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h01;
      default: b = 8'h02;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] row_offset(input logic [1:0] line_index);
    logic [7:0] b;
    case (line_index)
      2'd0: b = 8'h00;
      2'd1: b = 8'h40;
      2'd2: b = 8'h14;
      default: b = 8'h54;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/char_lcd_nibble_sequencer_core.sv =====
// Top level of the character LCD nibble sequencer for a 4-bit LCD behind a port expander.
//
// The input channel takes one request word (cmd, value, column, line_index,
// glyph_slot) when in_valid is high and in_stall is low. The output channel
// carries one expander port word per handshake, with out_last marking the
// final word of a request.
// A request accepted at one edge is held in the controller state register,
// which then issues its first port word into the output register. Words
// follow one per cycle while the receiver does not stall: 7 for instruction,
// data, cursor and glyph address, 14 for clear plus home, 2 for a backlight
// strobe and 50 for the init sequence. in_stall is high from the accepting
// edge until the edge that issues the final word, since the controller works
// through one request at a time.
// An unused command code is accepted and yields no words.
// When out_stall is high the output word holds and sequencing pauses.
// Reset empties the output register and sets the tracked port word to 0xFF.
`include "char_lcd_nibble_sequencer_core_defines.svh"
module char_lcd_nibble_sequencer_core import lcdns_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_cmd,
  input  logic [7:0] in_value,
  input  logic [5:0] in_column,
  input  logic [1:0] in_line_index,
  input  logic [2:0] in_glyph_slot,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_port_byte,
  output logic       out_last
);

  lcdns_cmd_t cmd;
  logic       out_free;

  lcdns_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .out_free (out_free),
    .cmd      (cmd)
  );

  lcdns_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_cmd        (in_cmd),
    .in_value      (in_value),
    .in_column     (in_column),
    .in_line_index (in_line_index),
    .in_glyph_slot (in_glyph_slot),
    .out_free      (out_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_port_byte (out_port_byte),
    .out_last      (out_last)
  );

  `LCDNS_ASSERT_IMPLY(a_issue_has_room, cmd.issue, out_free)
  `LCDNS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall && (in_cmd != CMD_NONE), in_stall)
  `LCDNS_ASSERT_NEXT(a_idle_after_tail, cmd.issue && cmd.tail, !in_stall && out_valid && out_last)

endmodule

// ===== rtl/lcdns_ctrl.sv =====
// Controller state machine that sequences the port words of each request.
module lcdns_ctrl import lcdns_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_cmd,
  output logic       in_stall,
  input  logic       out_free,
  output lcdns_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PRE  = 2'd1;
  localparam logic [1:0] ST_SEND = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [2:0] cmd_r, cmd_nxt;
  logic       send_done;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    send_done = (cmd_r == CMD_INIT) ? (idx_r == INIT_LAST_IDX) :
                (cmd_r == CMD_CLEAR) ? (idx_r == CLEAR_LAST_IDX) : 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    idx_nxt   = idx_r;
    cmd_nxt   = cmd_r;
    cmd.issue = 1'b0;
    cmd.load  = 1'b0;
    cmd.kind  = K_IDLE;
    cmd.sel   = SEL_REQ;
    cmd.idx   = idx_r;
    cmd.tail  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd_nxt  = in_cmd;
          idx_nxt  = 3'd0;
          if (in_cmd == CMD_INIT) begin
            state_nxt = ST_PRE;
            step_nxt  = 3'd0;
          end else if (in_cmd == CMD_STROBE) begin
            state_nxt = ST_PRE;
            step_nxt  = PRE_STROBE_STEP;
          end else if (in_cmd != CMD_NONE) begin
            state_nxt = ST_SEND;
            step_nxt  = 3'd0;
          end
        end
      end
      ST_PRE: begin
        cmd.kind = prefix_kind(step_r);
        if (out_free) begin
          cmd.issue = 1'b1;
          if (step_r == PRE_LAST_STEP) begin
            if (cmd_r == CMD_STROBE) begin
              cmd.tail  = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = ST_SEND;
              step_nxt  = 3'd0;
            end
          end else begin
            step_nxt = step_r + 3'd1;
          end
        end
      end
      ST_SEND: begin
        cmd.kind = send_kind(step_r);
        cmd.sel  = (cmd_r == CMD_INIT) ? SEL_INIT :
                   (cmd_r == CMD_CLEAR) ? SEL_CLEAR : SEL_REQ;
        if (out_free) begin
          cmd.issue = 1'b1;
          if (step_r == SEND_LAST_STEP) begin
            step_nxt = 3'd0;
            if (send_done) begin
              cmd.tail  = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              idx_nxt = idx_r + 3'd1;
            end
          end else begin
            step_nxt = step_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= 3'd0;
      idx_r   <= 3'd0;
      cmd_r   <= CMD_NONE;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      idx_r   <= idx_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

endmodule

// ===== rtl/lcdns_dp.sv =====
// Datapath that builds port words, tracks the last port word and holds the output word.
module lcdns_dp import lcdns_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  lcdns_cmd_t cmd,
  input  logic [2:0] in_cmd,
  input  logic [7:0] in_value,
  input  logic [5:0] in_column,
  input  logic [1:0] in_line_index,
  input  logic [2:0] in_glyph_slot,
  output logic       out_free,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_port_byte,
  output logic       out_last
);

  logic [7:0] req_r, req_nxt;
  logic [7:0] rs_r, rs_nxt;
  logic [7:0] last_r;
  logic [7:0] port_nxt;
  logic [7:0] cur_byte;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       tail_r;

  always_comb begin
    case (in_cmd)
      CMD_CURSOR: req_nxt = CURSOR_BASE | ({2'b00, in_column} + row_offset(in_line_index));
      CMD_GLYPH:  req_nxt = CGRAM_BASE | {2'b00, in_glyph_slot, 3'b000};
      default:    req_nxt = in_value;
    endcase
    rs_nxt = (in_cmd == CMD_DATA) ? PORT_RS : 8'h00;
  end

  always_comb begin
    case (cmd.sel)
      SEL_INIT:  cur_byte = init_byte(cmd.idx);
      SEL_CLEAR: cur_byte = clear_byte(cmd.idx);
      default:   cur_byte = req_r;
    endcase
    case (cmd.kind)
      K_HI:    port_nxt = rs_r | (cur_byte & NIB_HI) | PORT_BL;
      K_LO:    port_nxt = rs_r | {cur_byte[3:0], 4'b0000} | PORT_BL;
      K_ON:    port_nxt = last_r | PORT_EN | PORT_BL;
      K_OFF:   port_nxt = (last_r & PORT_NEN) | PORT_BL;
      K_X38:   port_nxt = INIT_8BIT | PORT_BL;
      K_X28:   port_nxt = INIT_4BIT | PORT_BL;
      default: port_nxt = PORT_BL;
    endcase
  end

  assign out_free      = !valid_r || !out_stall;
  assign out_valid     = valid_r;
  assign out_port_byte = byte_r;
  assign out_last      = tail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      last_r  <= PORT_RESET;
    end else begin
      if (cmd.issue) begin
        valid_r <= 1'b1;
        last_r  <= port_nxt;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req_nxt;
      rs_r  <= rs_nxt;
    end
    if (cmd.issue) begin
      byte_r <= port_nxt;
      tail_r <= cmd.tail;
    end
  end

endmodule
